@@ hw/rtl/gds_pkg.sv @@
// ----------------------------------------------------------------------------
// gds_pkg
// Shared types, codes and calendar helper functions for the Gregorian date
// shift block.
// ----------------------------------------------------------------------------
package gds_pkg;

    localparam int YEAR_W  = 12;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int SHIFT_W = 16;
    localparam int DN_W    = 17;
    localparam int WD_W    = 3;
    localparam int STAT_W  = 2;

    localparam logic [MONTH_W-1:0] LAST_MONTH = 4'd12;

    // Result status codes.
    localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STAT_W-1:0] STAT_BAD_DATE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_RANGE    = 2'd2;

    typedef struct packed {
        logic [YEAR_W-1:0]         in_year;
        logic [MONTH_W-1:0]        in_month;
        logic [DAY_W-1:0]          in_day;
        logic signed [SHIFT_W-1:0] days_earlier;
    } t_in_word;

    typedef struct packed {
        logic [DN_W-1:0]    day_number;
        logic [YEAR_W-1:0]  out_year;
        logic [MONTH_W-1:0] out_month;
        logic [DAY_W-1:0]   out_day;
        logic [WD_W-1:0]    weekday;
        logic [STAT_W-1:0]  status;
    } t_out_word;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_YFWD,
        ST_MFWD,
        ST_SHIFT,
        ST_RCHK,
        ST_YBACK,
        ST_MBACK,
        ST_EMIT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              load;
        logic              yr_fwd;
        logic              mon_fwd;
        logic              add_day;
        logic              apply_shift;
        logic              yr_back;
        logic              mon_back;
        logic              emit;
        logic [STAT_W-1:0] code;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic basic_ok;
        logic year_hit;
        logic day_ok;
        logic mon_hit;
        logic shift_ok;
        logic year_done;
        logic month_done;
        logic out_free;
    } t_dp_stat;

    // Length of a month; codes outside 1..12 give zero.
    function automatic logic [DAY_W-1:0] f_month_days(input logic [MONTH_W-1:0] m,
                                                      input logic leap);
        logic [DAY_W-1:0] d;
        case (m) inside
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    d = 5'd30;
            4'd2:                                       d = leap ? 5'd29 : 5'd28;
            default:                                    d = 5'd0;
        endcase
        return d;
    endfunction

    // Weekday advance, both operands already below seven.
    function automatic logic [WD_W-1:0] f_add_mod7(input logic [WD_W-1:0] w,
                                                   input logic [WD_W-1:0] k);
        logic [WD_W:0] s;
        s = {1'b0, w} + {1'b0, k};
        if (s >= 4'd7) begin
            s = s - 4'd7;
        end
        return s[WD_W-1:0];
    endfunction

    // Remainder by seven of a value no larger than 41.
    function automatic logic [WD_W-1:0] f_mod7_6b(input logic [5:0] v);
        logic [5:0] r;
        r = v;
        for (int i = 0; i < 5; i++) begin
            if (r >= 6'd7) begin
                r = r - 6'd7;
            end
        end
        return r[WD_W-1:0];
    endfunction

    // Elaboration-time helpers.
    function automatic int f_leaps_upto(input int n);
        return n / 4 - n / 100 + n / 400;
    endfunction

    function automatic int f_days_before(input int base, input int y);
        return (y - base) * 365 + f_leaps_upto(y - 1) - f_leaps_upto(base - 1);
    endfunction

    // Weekday of 1 January of year y, 0 is Monday.
    function automatic int f_jan1_weekday(input int y);
        int yy;
        yy = y - 1;
        return (35 + yy + yy / 4 - yy / 100 + yy / 400) % 7;
    endfunction

endpackage

@@ hw/rtl/gds_ctrl.sv @@
// ----------------------------------------------------------------------------
// gds_ctrl
// Sequencer for the date shift: validates the input, walks years and months
// forward to build the day count, applies the shift and walks back to a date.
// ----------------------------------------------------------------------------
module gds_ctrl
    import gds_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state            r_state, n_state;
    logic [STAT_W-1:0] r_code, n_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_code  <= STAT_OK;
        end else begin
            r_state <= n_state;
            r_code  <= n_code;
        end
    end

    assign o_in_stall = (r_state != ST_IDLE);

    always_comb begin
        n_state = r_state;
        n_code  = r_code;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (i_stat.basic_ok) begin
                    n_state = ST_YFWD;
                end else begin
                    n_code  = STAT_BAD_DATE;
                    n_state = ST_EMIT;
                end
            end
            ST_YFWD: begin
                if (i_stat.year_hit) begin
                    // The leap flag of the input year is known only here.
                    if (i_stat.day_ok) begin
                        n_state = ST_MFWD;
                    end else begin
                        n_code  = STAT_BAD_DATE;
                        n_state = ST_EMIT;
                    end
                end else begin
                    o_cmd.yr_fwd = 1'b1;
                end
            end
            ST_MFWD: begin
                if (i_stat.mon_hit) begin
                    o_cmd.add_day = 1'b1;
                    n_state       = ST_SHIFT;
                end else begin
                    o_cmd.mon_fwd = 1'b1;
                end
            end
            ST_SHIFT: begin
                o_cmd.apply_shift = 1'b1;
                n_state           = ST_RCHK;
            end
            ST_RCHK: begin
                if (i_stat.shift_ok) begin
                    n_state = ST_YBACK;
                end else begin
                    n_code  = STAT_RANGE;
                    n_state = ST_EMIT;
                end
            end
            ST_YBACK: begin
                if (i_stat.year_done) begin
                    n_state = ST_MBACK;
                end else begin
                    o_cmd.yr_back = 1'b1;
                end
            end
            ST_MBACK: begin
                if (i_stat.month_done) begin
                    n_code  = STAT_OK;
                    n_state = ST_EMIT;
                end else begin
                    o_cmd.mon_back = 1'b1;
                end
            end
            ST_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.code = r_code;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

@@ hw/rtl/gds_datapath.sv @@
// ----------------------------------------------------------------------------
// gds_datapath
// Year and month walker with leap tracking, day count accumulator, weekday
// tracker and the result register.
// ----------------------------------------------------------------------------
module gds_datapath
    import gds_pkg::*;
#(
    parameter int BASE_YEAR = 1900,
    parameter int YEAR_SPAN = 256
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_word  i_in_word,
    input  logic      i_out_stall,
    input  t_dp_cmd   i_cmd,
    output t_dp_stat  o_stat,
    output logic      o_out_valid,
    output t_out_word o_out_word
);

    localparam int LAST_YEAR = BASE_YEAR + YEAR_SPAN - 1;
    localparam int TOTAL     = f_days_before(BASE_YEAR, LAST_YEAR + 1);
    localparam int CNT_W     = $clog2(TOTAL + 1);
    localparam int ACC_W     = ((CNT_W > SHIFT_W) ? CNT_W : SHIFT_W) + 2;

    localparam logic [YEAR_W-1:0] BASE_Y   = YEAR_W'(BASE_YEAR);
    localparam logic [YEAR_W-1:0] LAST_Y   = YEAR_W'(LAST_YEAR);
    localparam logic [1:0]        BASE_M4  = 2'(BASE_YEAR % 4);
    localparam logic [6:0]        BASE_M100 = 7'(BASE_YEAR % 100);
    localparam logic [8:0]        BASE_M400 = 9'(BASE_YEAR % 400);
    localparam logic [WD_W-1:0]   BASE_WD  = WD_W'(f_jan1_weekday(BASE_YEAR));

    localparam logic signed [ACC_W-1:0] ACC_ONE   = ACC_W'(1);
    localparam logic signed [ACC_W-1:0] ACC_TOTAL = ACC_W'(TOTAL);

    t_in_word                r_in;
    logic [YEAR_W-1:0]       r_ry;
    logic [1:0]              r_m4;
    logic [6:0]              r_m100;
    logic [8:0]              r_m400;
    logic [MONTH_W-1:0]      r_mon;
    logic [WD_W-1:0]         r_wd;
    logic signed [ACC_W-1:0] r_acc;
    logic [CNT_W-1:0]        r_dn;
    logic                    r_out_valid;
    t_out_word               r_out;
    t_out_word               n_out;

    logic                    leap;
    logic [8:0]              ylen;
    logic [DAY_W-1:0]        mdays_walk;
    logic [DAY_W-1:0]        mdays_in;
    logic signed [ACC_W-1:0] acc_ylen;
    logic signed [ACC_W-1:0] acc_mdays;
    logic signed [ACC_W-1:0] acc_day;
    logic signed [ACC_W-1:0] acc_shift;
    logic signed [ACC_W-1:0] acc_plus_day;
    logic [WD_W-1:0]         wd_mon_step;
    logic [WD_W-1:0]         wd_final;
    logic                    out_free;

    // Leap flag of the year the walker sits on, kept by its own residues.
    assign leap = ((r_m4 == 2'd0) && (r_m100 != 7'd0)) || (r_m400 == 9'd0);
    assign ylen = leap ? 9'd366 : 9'd365;

    assign mdays_walk = f_month_days(r_mon, leap);
    assign mdays_in   = f_month_days(r_in.in_month, leap);

    assign acc_ylen     = ACC_W'(ylen);
    assign acc_mdays    = ACC_W'(mdays_walk);
    assign acc_day      = ACC_W'(r_in.in_day);
    assign acc_shift    = {{(ACC_W - SHIFT_W){r_in.days_earlier[SHIFT_W-1]}},
                           r_in.days_earlier};
    assign acc_plus_day = r_acc + acc_day;

    // Month lengths 28..31 leave remainders 0..3 by seven.
    assign wd_mon_step = WD_W'(mdays_walk - 5'd28);
    assign wd_final    = f_mod7_6b(6'({3'b000, r_wd}) + 6'(r_acc[DAY_W-1:0]) - 6'd1);

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        o_stat.basic_ok   = (r_in.in_year >= BASE_Y) && (r_in.in_year <= LAST_Y) &&
                            (r_in.in_month != 4'd0) && (r_in.in_month <= LAST_MONTH) &&
                            (r_in.in_day != 5'd0);
        o_stat.year_hit   = (r_ry == r_in.in_year);
        o_stat.day_ok     = (r_in.in_day <= mdays_in);
        o_stat.mon_hit    = (r_mon == r_in.in_month);
        o_stat.shift_ok   = (r_acc >= ACC_ONE) && (r_acc <= ACC_TOTAL);
        o_stat.year_done  = !((r_ry < LAST_Y) && (r_acc > acc_ylen));
        o_stat.month_done = !((r_mon < LAST_MONTH) && (r_acc > acc_mdays));
        o_stat.out_free   = out_free;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_in <= i_in_word;
        end

        if (i_cmd.load || i_cmd.apply_shift) begin
            r_ry   <= BASE_Y;
            r_m4   <= BASE_M4;
            r_m100 <= BASE_M100;
            r_m400 <= BASE_M400;
            r_mon  <= 4'd1;
            r_wd   <= BASE_WD;
        end else if (i_cmd.yr_fwd || i_cmd.yr_back) begin
            r_ry   <= r_ry + 12'd1;
            r_m4   <= r_m4 + 2'd1;
            r_m100 <= (r_m100 == 7'd99) ? 7'd0 : r_m100 + 7'd1;
            r_m400 <= (r_m400 == 9'd399) ? 9'd0 : r_m400 + 9'd1;
            if (i_cmd.yr_back) begin
                r_wd <= f_add_mod7(r_wd, leap ? 3'd2 : 3'd1);
            end
        end else if (i_cmd.mon_fwd || i_cmd.mon_back) begin
            r_mon <= r_mon + 4'd1;
            if (i_cmd.mon_back) begin
                r_wd <= f_add_mod7(r_wd, wd_mon_step);
            end
        end

        if (i_cmd.load) begin
            r_acc <= '0;
        end else if (i_cmd.yr_fwd) begin
            r_acc <= r_acc + acc_ylen;
        end else if (i_cmd.mon_fwd) begin
            r_acc <= r_acc + acc_mdays;
        end else if (i_cmd.add_day) begin
            r_acc <= acc_plus_day;
        end else if (i_cmd.apply_shift) begin
            r_acc <= r_acc - acc_shift;
        end else if (i_cmd.yr_back) begin
            r_acc <= r_acc - acc_ylen;
        end else if (i_cmd.mon_back) begin
            r_acc <= r_acc - acc_mdays;
        end

        if (i_cmd.add_day) begin
            r_dn <= CNT_W'(acc_plus_day);
        end
    end

    // Result register: a finished word waits here while the sink stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_comb begin
        n_out        = '0;
        n_out.status = i_cmd.code;
        if (i_cmd.code != STAT_BAD_DATE) begin
            n_out.day_number = DN_W'(r_dn);
        end
        if (i_cmd.code == STAT_OK) begin
            n_out.out_year  = r_ry;
            n_out.out_month = r_mon;
            n_out.out_day   = r_acc[DAY_W-1:0];
            n_out.weekday   = wd_final;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

@@ hw/rtl/gregorian_date_shift_top.sv @@
// ----------------------------------------------------------------------------
// gregorian_date_shift_top
// Converts a Gregorian date to a day count from 1 January of BASE_YEAR, moves
// it earlier by a signed number of days and converts it back to a date with
// its weekday and a status code.
//
//   Channel   Signals                              Word type
//   input     i_in_valid, o_in_stall, i_in_word    t_in_word
//   output    o_out_valid, i_out_stall, o_out_word t_out_word
//
// One word is worked on at a time: the input stalls from the acceptance of a
// word until its result is handed to the result register. The forward walk
// steps through the years and months to build the day count, and the
// backward walk steps again through the same year and month walker.
// Reset is synchronous and active low; it returns the sequencer to idle and
// empties the result register. A finished word waits in the result register
// while the sink stalls, and the next input word is taken meanwhile.
// ----------------------------------------------------------------------------
module gregorian_date_shift_top
    import gds_pkg::*;
#(
    parameter int BASE_YEAR = 1900,
    parameter int YEAR_SPAN = 256
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    gds_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    gds_datapath #(
        .BASE_YEAR (BASE_YEAR),
        .YEAR_SPAN (YEAR_SPAN)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_word   (i_in_word),
        .i_out_stall (i_out_stall),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

endmodule

@@ sim/gregorian_date_shift_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gregorian_date_shift_top_tb
// Self-checking bench for the Gregorian date shift block. A scoreboard class
// works out the expected day count, shifted date, weekday and status for
// every accepted input word. It compares each output word with the oldest
// pending prediction. Directed corner dates are followed by random dates with
// random shifts, while both sides idle and stall at random.
// ----------------------------------------------------------------------------
module gregorian_date_shift_top_tb;
    import gds_pkg::*;

    localparam int BASE_YEAR    = 1900;
    localparam int YEAR_SPAN    = 256;
    localparam int LAST_YEAR    = BASE_YEAR + YEAR_SPAN - 1;
    localparam int RANDOM_WORDS = 1450;
    localparam int DRAIN_CYCLES = 2 * YEAR_SPAN + 90;
    localparam int HOLD_AT      = 300;
    localparam int HOLD_CYCLES  = 1500;
    localparam int STALL_LIMIT  = 20000;

    class shift_scoreboard;
        t_out_word expected_dates[$];
        int        taken;
        int        checked;
        int        mismatches;
        int        n_ok;
        int        n_bad_date;
        int        n_range;

        static function bit leap_year(int y);
            return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
        endfunction

        static function int month_len(int y, int m);
            case (m)
                1, 3, 5, 7, 8, 10, 12: return 31;
                4, 6, 9, 11:           return 30;
                2:                     return leap_year(y) ? 29 : 28;
                default:               return 0;
            endcase
        endfunction

        static function int leaps_through(int n);
            return n / 4 - n / 100 + n / 400;
        endfunction

        static function int days_before_year(int y);
            return (y - BASE_YEAR) * 365 + leaps_through(y - 1)
                 - leaps_through(BASE_YEAR - 1);
        endfunction

        static function t_out_word predict_shift(t_in_word w);
            int        y;
            int        m;
            int        d;
            int        shift;
            int        dn;
            int        target;
            int        ry;
            int        rm;
            int        wy;
            int        wm;
            int        wd;
            t_out_word r;
            y     = w.in_year;
            m     = w.in_month;
            d     = w.in_day;
            shift = w.days_earlier;
            r     = '0;
            if (y < BASE_YEAR || y > LAST_YEAR || m < 1 || m > 12 ||
                d < 1 || d > month_len(y, m)) begin
                r.status = STAT_BAD_DATE;
                return r;
            end
            dn = days_before_year(y) + d;
            for (int i = 1; i < m; i++) begin
                dn += month_len(y, i);
            end
            r.day_number = dn[DN_W-1:0];
            target = dn - shift;
            if (target < 1 || target > days_before_year(LAST_YEAR + 1)) begin
                r.status = STAT_RANGE;
                return r;
            end
            ry = BASE_YEAR;
            while (ry < LAST_YEAR && target > 365 + int'(leap_year(ry))) begin
                target -= 365 + int'(leap_year(ry));
                ry++;
            end
            rm = 1;
            while (rm < 12 && target > month_len(ry, rm)) begin
                target -= month_len(ry, rm);
                rm++;
            end
            // January and February count as months 13 and 14 of the year before.
            wy = ry;
            wm = rm;
            if (wm <= 2) begin
                wm += 12;
                wy -= 1;
            end
            wd = (target + 2 * wm + 3 * (wm + 1) / 5 + wy + wy / 4 - wy / 100
                + wy / 400) % 7;
            r.out_year  = ry[YEAR_W-1:0];
            r.out_month = rm[MONTH_W-1:0];
            r.out_day   = target[DAY_W-1:0];
            r.weekday   = wd[WD_W-1:0];
            r.status    = STAT_OK;
            return r;
        endfunction

        function void note_input(t_in_word w);
            expected_dates.push_back(predict_shift(w));
            taken++;
        endfunction

        function void compare_field(string name, int want, int got);
            if (want != got) begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(t_out_word got);
            t_out_word want;
            if (expected_dates.size() == 0) begin
                $error("output word with no pending input: %p", got);
                mismatches++;
                return;
            end
            want = expected_dates.pop_front();
            checked++;
            compare_field("day_number", want.day_number, got.day_number);
            compare_field("out_year", want.out_year, got.out_year);
            compare_field("out_month", want.out_month, got.out_month);
            compare_field("out_day", want.out_day, got.out_day);
            compare_field("weekday", want.weekday, got.weekday);
            compare_field("status", want.status, got.status);
            case (want.status)
                STAT_OK:       n_ok++;
                STAT_BAD_DATE: n_bad_date++;
                default:       n_range++;
            endcase
        endfunction
    endclass

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_stall;
    t_in_word  i_in_word   = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_word o_out_word;

    shift_scoreboard date_board = new();
    bit              quiet      = 1'b0;
    bit              held_off   = 1'b0;
    int              idle_cycles = 0;
    t_in_word        directed_words[$];

    gregorian_date_shift_top #(
        .BASE_YEAR(BASE_YEAR),
        .YEAR_SPAN(YEAR_SPAN)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_word  (i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_word (o_out_word)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            date_board.note_input(i_in_word);
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            date_board.check_result(o_out_word);
        end
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
        end
        $display("Regression FAIL");
        $finish;
    end

    // Sink side: random stalls, plus one long hold-off that backs the block up.
    initial begin
        forever begin
            @(posedge i_clk);
            if (!held_off && date_board.taken >= HOLD_AT) begin
                held_off = 1'b1;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            i_out_stall <= !quiet && ($urandom_range(0, 99) < 22);
        end
    end

    function automatic t_in_word make_word(int y, int m, int d, int s);
        t_in_word w;
        w.in_year      = y[YEAR_W-1:0];
        w.in_month     = m[MONTH_W-1:0];
        w.in_day       = d[DAY_W-1:0];
        w.days_earlier = s[SHIFT_W-1:0];
        return w;
    endfunction

    function automatic t_in_word random_word();
        int          kind;
        int          y;
        int          m;
        int          d;
        int          s;
        logic [63:0] noise;
        kind = $urandom_range(0, 99);
        y    = $urandom_range(BASE_YEAR, LAST_YEAR);
        m    = $urandom_range(1, 12);
        d    = $urandom_range(1, shift_scoreboard::month_len(y, m));
        s    = $urandom_range(0, 65535);
        s    = s - 32768;
        if (kind < 20) begin
            s = $urandom_range(0, 800);
            s = s - 400;
        end else if (kind < 30) begin
            // Month ends and leap days, stepped over by a few days.
            d = shift_scoreboard::month_len(y, m);
            s = $urandom_range(0, 6);
            s = s - 3;
        end else if (kind < 40) begin
            // Dates near either end of the supported years.
            if ($urandom_range(0, 1)) begin
                y = BASE_YEAR;
                m = 1;
            end else begin
                y = LAST_YEAR;
                m = 12;
            end
            d = $urandom_range(1, 31);
            s = $urandom_range(0, 120);
            s = s - 60;
        end else if (kind < 46) begin
            d = shift_scoreboard::month_len(y, m) + 1;
        end else if (kind < 52) begin
            noise = {$urandom(), $urandom()};
            return noise[$bits(t_in_word)-1:0];
        end
        return make_word(y, m, d, s);
    endfunction

    task automatic offer_word(input t_in_word w);
        while (!quiet && $urandom_range(0, 99) < 22) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
    endtask

    initial begin
        directed_words.push_back(make_word(1900, 1, 1, 0));
        directed_words.push_back(make_word(1900, 1, 1, 1));
        directed_words.push_back(make_word(1900, 1, 1, -32768));
        directed_words.push_back(make_word(2155, 12, 31, 0));
        directed_words.push_back(make_word(2155, 12, 31, -1));
        directed_words.push_back(make_word(2155, 12, 31, 32767));
        directed_words.push_back(make_word(2000, 2, 29, 0));
        directed_words.push_back(make_word(1900, 2, 29, 0));
        directed_words.push_back(make_word(2001, 2, 29, 5));
        directed_words.push_back(make_word(2004, 2, 29, 366));
        // Landing on a leap day from the first of March.
        directed_words.push_back(make_word(2024, 3, 1, 1));
        directed_words.push_back(make_word(2020, 12, 31, -1));
        directed_words.push_back(make_word(1899, 12, 31, 0));
        directed_words.push_back(make_word(2156, 1, 1, 0));
        directed_words.push_back(make_word(4095, 15, 31, -1));
        directed_words.push_back(make_word(0, 1, 1, 0));
        directed_words.push_back(make_word(2010, 0, 10, 0));
        directed_words.push_back(make_word(2010, 13, 10, 0));
        directed_words.push_back(make_word(2010, 6, 0, 0));
        directed_words.push_back(make_word(2020, 4, 31, 0));
        directed_words.push_back(make_word(2020, 1, 31, 32767));
        directed_words.push_back(make_word(1950, 12, 31, -32768));

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_words[k]) begin
            offer_word(directed_words[k]);
        end
        for (int k = 0; k < RANDOM_WORDS; k++) begin
            quiet = (k >= 600 && k < 800);
            offer_word(random_word());
        end
        quiet = 1'b0;
        i_in_valid <= 1'b0;

        while (date_board.expected_dates.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Checked %0d output words of %0d input words: %0d shifted, %0d bad dates,",
                 date_board.checked, date_board.taken, date_board.n_ok,
                 date_board.n_bad_date);
        $display("%0d shifts out of range, %0d field mismatches.",
                 date_board.n_range, date_board.mismatches);
        if (date_board.mismatches == 0 && date_board.expected_dates.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
